// ----- rtl/core/cmrs_pkg.sv -----
package cmrs_pkg;

  localparam int MAX_NODES = 4096;
  localparam int MAX_GRID  = 1024;
  localparam int NODE_AW   = 12;
  localparam int GRID_AW   = 10;
  localparam int NCNT_W    = 13;
  localparam int GCNT_W    = 11;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 44;
  localparam int CS_W      = 13;

  localparam logic [2:0] FN_LOAD_NODE  = 3'd0;
  localparam logic [2:0] FN_LOAD_COUNT = 3'd1;
  localparam logic [2:0] FN_DECOMPOSE  = 3'd2;
  localparam logic [2:0] FN_READ_MEAN  = 3'd3;
  localparam logic [2:0] FN_READ_RES   = 3'd4;
  localparam logic [2:0] FN_WRITE_GRID = 3'd5;
  localparam logic [2:0] FN_RECOMPOSE  = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic CFG_NODE_TOTAL = 1'b0;
  localparam logic CFG_GRID_TOTAL = 1'b1;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] dividend;
    logic [CS_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             sat;
  } sat_t;

  function automatic sat_t sat32(input logic signed [ACC_W:0] v);
    sat_t s;
    s.sat = 1'b1;
    if (v > 45'sh0_7FFF_FFFF) begin
      s.val = 32'h7FFF_FFFF;
    end else if (v < -45'sh0_8000_0000) begin
      s.val = 32'h8000_0000;
    end else begin
      s.val = v[VAL_W-1:0];
      s.sat = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/cmrs_div.sv -----
// Restoring divider: signed 44-bit dividend by unsigned nonzero 13-bit divisor,
// quotient truncated toward zero. One quotient bit per cycle.
module cmrs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  cmrs_pkg::div_req_t  req,
  output cmrs_pkg::div_rsp_t  rsp
);

  localparam int W = cmrs_pkg::ACC_W;

  logic [W-1:0]                quo_r, quo_nxt;
  logic [cmrs_pkg::CS_W:0]     rem_r, rem_nxt;
  logic [cmrs_pkg::CS_W-1:0]   dvs_r;
  logic [5:0]                  cnt_r;
  logic                        run_r, neg_r, done_r;
  logic [cmrs_pkg::CS_W:0]     rem_sh;

  always_comb begin
    rem_sh = {rem_r[cmrs_pkg::CS_W-1:0], quo_r[W-1]};
    if (rem_sh >= {1'b0, dvs_r}) begin
      rem_nxt = rem_sh - {1'b0, dvs_r};
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // last quotient bit lands this edge
      done_r <= run_r && !req.start && (cnt_r == 6'(W - 1));
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        neg_r <= req.dividend[W-1];
        quo_r <= req.dividend[W-1] ? W'(-req.dividend) : req.dividend;
        rem_r <= '0;
        dvs_r <= req.divisor;
      end else if (run_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 6'd1;
        run_r <= (cnt_r != 6'(W - 1));
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? W'(-quo_r) : quo_r;

endmodule

// ----- rtl/core/cluster_mean_residual_split.sv -----
// Cluster mean / residual splitter for mesh node values (Q16.16).
// Input channel: an item (in_func, indexes, value, count) is taken on a clock
// edge with start high and busy low. busy stays high while the item is worked.
// Result channel: one result per item, out_strobe high for exactly one cycle
// with out_result_value and out_status; the receiver cannot hold it off, so
// no result is ever stalled or lost.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 node_total,
// 1 grid_total) and cfg_data; cfg_ready is always high. Write only while idle.
// Flow: loads, writes, unused codes and out-of-range items finish in S_EXEC;
// in-range reads and recomposes also pass S_WAIT1, and a recompose whose
// target is in range S_WAIT2. The node, target and count memories each have
// one port, the grid memory separate read and write addresses; all have
// registered read data. Decompose: clears the grid store, sums node values
// per target, divides each sum by its count in the shared bit-serial divider
// (0 for an empty cluster), then subtracts each mean from its nodes in place.
// Reset: a clearing pass zeroes the grid store; busy is high
// during it. Config writes are taken during it.
module cluster_mean_residual_split (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_func,
  input  logic [cmrs_pkg::NODE_AW-1:0]        in_node_index,
  input  logic [cmrs_pkg::GRID_AW-1:0]        in_grid_index,
  input  logic signed [cmrs_pkg::VAL_W-1:0]   in_sample_value,
  input  logic [cmrs_pkg::CS_W-1:0]           in_cluster_size,
  output logic                                out_strobe,
  output logic signed [cmrs_pkg::VAL_W-1:0]   out_result_value,
  output logic [1:0]                          out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [cmrs_pkg::NCNT_W-1:0]         cfg_data
);

  typedef enum logic [14:0] {
    S_CLR   = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_EXEC  = 15'b000000000000100,
    S_WAIT1 = 15'b000000000001000,
    S_WAIT2 = 15'b000000000010000,
    S_DCLR  = 15'b000000000100000,
    S_ACC_A = 15'b000000001000000,
    S_ACC_B = 15'b000000010000000,
    S_ACC_C = 15'b000000100000000,
    S_DIV_A = 15'b000001000000000,
    S_DIV_B = 15'b000010000000000,
    S_DIV_C = 15'b000100000000000,
    S_RES_A = 15'b001000000000000,
    S_RES_B = 15'b010000000000000,
    S_RES_C = 15'b100000000000000
  } state_t;

  localparam int AW = cmrs_pkg::ACC_W;
  localparam int VW = cmrs_pkg::VAL_W;

  state_t state_r, state_nxt;

  // config
  logic [cmrs_pkg::NCNT_W-1:0] node_total_r;
  logic [cmrs_pkg::GCNT_W-1:0] grid_total_r;
  logic [cmrs_pkg::NCNT_W-1:0] nn;
  logic [cmrs_pkg::GCNT_W-1:0] ng;

  // latched item
  logic [2:0]                   func_r;
  logic [cmrs_pkg::NODE_AW-1:0] ni_r;
  logic [cmrs_pkg::GRID_AW-1:0] gi_r;
  logic [VW-1:0]                sv_r;
  logic [cmrs_pkg::CS_W-1:0]    cs_r;

  // sweep counter, sticky saturation
  logic [cmrs_pkg::NCNT_W-1:0] idx_r, idx_nxt, idx_inc;
  logic                        sat_r, sat_nxt;

  // result regs
  logic          out_strobe_r;
  logic [VW-1:0] out_value_r;
  logic [1:0]    out_status_r;
  logic          fin;
  logic [VW-1:0] fin_val;
  logic [1:0]    fin_st;

  // memories
  logic [VW-1:0]                nv_mem [cmrs_pkg::MAX_NODES];
  logic [cmrs_pkg::GRID_AW-1:0] nt_mem [cmrs_pkg::MAX_NODES];
  logic [cmrs_pkg::CS_W-1:0]    cs_mem [cmrs_pkg::MAX_GRID];
  logic [AW-1:0]                g_mem  [cmrs_pkg::MAX_GRID];

  logic [cmrs_pkg::NODE_AW-1:0] node_addr;
  logic                         nv_we, nt_we;
  logic [VW-1:0]                nv_wdata;
  logic signed [VW-1:0]         nv_q;
  logic [cmrs_pkg::GRID_AW-1:0] nt_q;

  logic [cmrs_pkg::GRID_AW-1:0] cs_addr;
  logic                         cs_we;
  logic [cmrs_pkg::CS_W-1:0]    cs_q;

  logic [cmrs_pkg::GRID_AW-1:0] g_raddr, g_waddr;
  logic                         g_we;
  logic [AW-1:0]                g_wdata;
  logic signed [AW-1:0]         g_q;

  logic                nok, gok, tok;
  cmrs_pkg::sat_t      s_mean, s_rec, s_res;
  cmrs_pkg::div_req_t  div_req;
  cmrs_pkg::div_rsp_t  div_rsp;

  assign nn = (node_total_r > cmrs_pkg::NCNT_W'(cmrs_pkg::MAX_NODES)) ?
              cmrs_pkg::NCNT_W'(cmrs_pkg::MAX_NODES) : node_total_r;
  assign ng = (grid_total_r > cmrs_pkg::GCNT_W'(cmrs_pkg::MAX_GRID)) ?
              cmrs_pkg::GCNT_W'(cmrs_pkg::MAX_GRID) : grid_total_r;

  assign nok = {1'b0, ni_r} < nn;
  assign gok = {1'b0, gi_r} < ng;
  assign tok = {1'b0, nt_q} < ng;
  assign idx_inc = idx_r + 13'd1;

  assign s_mean = cmrs_pkg::sat32({g_q[AW-1], g_q});
  assign s_rec  = cmrs_pkg::sat32({{(AW-VW+1){sv_r[VW-1]}}, sv_r} + {g_q[AW-1], g_q});
  assign s_res  = cmrs_pkg::sat32({{(AW-VW+1){nv_q[VW-1]}}, nv_q} - {g_q[AW-1], g_q});

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  cmrs_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    sat_nxt          = sat_r;
    fin              = 1'b0;
    fin_val          = '0;
    fin_st           = cmrs_pkg::ST_OK;
    node_addr        = ni_r;
    nv_we            = 1'b0;
    nt_we            = 1'b0;
    nv_wdata         = sv_r;
    cs_addr          = gi_r;
    cs_we            = 1'b0;
    g_raddr          = gi_r;
    g_waddr          = gi_r;
    g_we             = 1'b0;
    g_wdata          = {{(AW-VW){sv_r[VW-1]}}, sv_r};
    div_req.start    = 1'b0;
    div_req.dividend = g_q;
    div_req.divisor  = cs_q;

    case (state_r)
      S_CLR: begin
        g_we    = 1'b1;
        g_waddr = idx_r[cmrs_pkg::GRID_AW-1:0];
        g_wdata = '0;
        idx_nxt = idx_inc;
        if (idx_inc == cmrs_pkg::NCNT_W'(cmrs_pkg::MAX_GRID)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (func_r)
          cmrs_pkg::FN_LOAD_NODE: begin
            fin = 1'b1;
            if (nok && gok) begin
              nv_we = 1'b1;
              nt_we = 1'b1;
            end else fin_st = cmrs_pkg::ST_RANGE;
          end
          cmrs_pkg::FN_LOAD_COUNT: begin
            fin = 1'b1;
            if (gok) cs_we = 1'b1;
            else fin_st = cmrs_pkg::ST_RANGE;
          end
          cmrs_pkg::FN_DECOMPOSE: begin
            idx_nxt   = '0;
            sat_nxt   = 1'b0;
            state_nxt = S_DCLR;
          end
          cmrs_pkg::FN_READ_MEAN: begin
            if (gok) state_nxt = S_WAIT1;
            else begin
              fin    = 1'b1;
              fin_st = cmrs_pkg::ST_RANGE;
            end
          end
          cmrs_pkg::FN_WRITE_GRID: begin
            fin = 1'b1;
            if (gok) g_we = 1'b1;
            else fin_st = cmrs_pkg::ST_RANGE;
          end
          cmrs_pkg::FN_READ_RES, cmrs_pkg::FN_RECOMPOSE: begin
            if (nok) state_nxt = S_WAIT1;
            else begin
              fin    = 1'b1;
              fin_st = cmrs_pkg::ST_RANGE;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_WAIT1: begin
        case (func_r)
          cmrs_pkg::FN_READ_MEAN: begin
            fin     = 1'b1;
            fin_val = s_mean.val;
            fin_st  = s_mean.sat ? cmrs_pkg::ST_SAT : cmrs_pkg::ST_OK;
          end
          cmrs_pkg::FN_READ_RES: begin
            fin     = 1'b1;
            fin_val = nv_q;
          end
          cmrs_pkg::FN_RECOMPOSE: begin
            g_raddr = nt_q;
            if (tok) state_nxt = S_WAIT2;
            else begin
              fin    = 1'b1;
              fin_st = cmrs_pkg::ST_RANGE;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_WAIT2: begin
        fin     = 1'b1;
        fin_val = s_rec.val;
        fin_st  = s_rec.sat ? cmrs_pkg::ST_SAT : cmrs_pkg::ST_OK;
      end
      // decompose: clear whole grid store
      S_DCLR: begin
        g_we    = 1'b1;
        g_waddr = idx_r[cmrs_pkg::GRID_AW-1:0];
        g_wdata = '0;
        idx_nxt = idx_inc;
        if (idx_inc == cmrs_pkg::NCNT_W'(cmrs_pkg::MAX_GRID)) begin
          idx_nxt = '0;
          if (nn != '0) state_nxt = S_ACC_A;
          else if (ng != '0) state_nxt = S_DIV_A;
          else fin = 1'b1;
        end
      end
      // sum node values per target
      S_ACC_A: begin
        node_addr = idx_r[cmrs_pkg::NODE_AW-1:0];
        state_nxt = S_ACC_B;
      end
      S_ACC_B: begin
        node_addr = idx_r[cmrs_pkg::NODE_AW-1:0];
        g_raddr   = nt_q;
        state_nxt = S_ACC_C;
      end
      S_ACC_C: begin
        node_addr = idx_r[cmrs_pkg::NODE_AW-1:0];
        g_raddr   = nt_q;
        g_waddr   = nt_q;
        g_wdata   = g_q + {{(AW-VW){nv_q[VW-1]}}, nv_q};
        g_we      = tok;
        idx_nxt   = idx_inc;
        state_nxt = S_ACC_A;
        if (idx_inc == nn) begin
          idx_nxt = '0;
          if (ng != '0) state_nxt = S_DIV_A;
          else fin = 1'b1;
        end
      end
      // divide each sum by its count
      S_DIV_A: begin
        g_raddr   = idx_r[cmrs_pkg::GRID_AW-1:0];
        cs_addr   = idx_r[cmrs_pkg::GRID_AW-1:0];
        state_nxt = S_DIV_B;
      end
      S_DIV_B: begin
        g_raddr       = idx_r[cmrs_pkg::GRID_AW-1:0];
        cs_addr       = idx_r[cmrs_pkg::GRID_AW-1:0];
        div_req.start = (cs_q != '0);
        state_nxt     = S_DIV_C;
      end
      S_DIV_C: begin
        g_raddr = idx_r[cmrs_pkg::GRID_AW-1:0];
        cs_addr = idx_r[cmrs_pkg::GRID_AW-1:0];
        g_waddr = idx_r[cmrs_pkg::GRID_AW-1:0];
        g_wdata = (cs_q == '0) ? '0 : div_rsp.quotient;
        if ((cs_q == '0) || div_rsp.done) begin
          g_we      = 1'b1;
          idx_nxt   = idx_inc;
          state_nxt = S_DIV_A;
          if (idx_inc == {2'b00, ng}) begin
            idx_nxt = '0;
            if (nn != '0) state_nxt = S_RES_A;
            else fin = 1'b1;
          end
        end
      end
      // subtract mean from each node in place
      S_RES_A: begin
        node_addr = idx_r[cmrs_pkg::NODE_AW-1:0];
        state_nxt = S_RES_B;
      end
      S_RES_B: begin
        node_addr = idx_r[cmrs_pkg::NODE_AW-1:0];
        g_raddr   = nt_q;
        state_nxt = S_RES_C;
      end
      S_RES_C: begin
        node_addr = idx_r[cmrs_pkg::NODE_AW-1:0];
        g_raddr   = nt_q;
        nv_wdata  = s_res.val;
        nv_we     = tok;
        if (tok && s_res.sat) sat_nxt = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_RES_A;
        if (idx_inc == nn) begin
          idx_nxt = '0;
          fin     = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
      if (func_r == cmrs_pkg::FN_DECOMPOSE) begin
        fin_st = sat_nxt ? cmrs_pkg::ST_SAT : cmrs_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      idx_r        <= '0;
      sat_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      node_total_r <= '0;
      grid_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      sat_r        <= sat_nxt;
      out_strobe_r <= fin;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cmrs_pkg::CFG_NODE_TOTAL: node_total_r <= cfg_data;
          cmrs_pkg::CFG_GRID_TOTAL: grid_total_r <= cfg_data[cmrs_pkg::GCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      func_r <= in_func;
      ni_r   <= in_node_index;
      gi_r   <= in_grid_index;
      sv_r   <= in_sample_value;
      cs_r   <= in_cluster_size;
    end
    if (fin) begin
      out_value_r  <= fin_val;
      out_status_r <= fin_st;
    end
  end

  // memories, registered read
  always_ff @(posedge clk) begin
    if (nv_we) nv_mem[node_addr] <= nv_wdata;
    if (nt_we) nt_mem[node_addr] <= gi_r;
    nv_q <= nv_mem[node_addr];
    nt_q <= nt_mem[node_addr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cs_addr] <= cs_r;
    cs_q <= cs_mem[cs_addr];
  end

  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_waddr] <= g_wdata;
    g_q <= g_mem[g_raddr];
  end

  assign out_strobe       = out_strobe_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

// ----- test/cluster_mean_residual_split_tb.sv -----
module cluster_mean_residual_split_tb;

  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 20000;

  // one input item as driven onto the in_ ports
  typedef struct {
    logic [2:0]        f;
    logic [11:0]       ni;
    logic [9:0]        gi;
    logic signed [31:0] sv;
    logic [12:0]       cs;
  } job_t;

  typedef struct {
    logic signed [31:0] v;
    logic [1:0]         s;
  } answer_t;

  // Mirrors the node/grid memories and predicts the answer of every item.
  class mean_split_board;
    int node_lim, grid_lim;
    logic signed [31:0] nval[cmrs_pkg::MAX_NODES];
    logic [9:0]         ntgt[cmrs_pkg::MAX_NODES];
    logic [12:0]        csz[cmrs_pkg::MAX_GRID];
    longint             gstore[cmrs_pkg::MAX_GRID];
    bit                 nw[cmrs_pkg::MAX_NODES];
    bit                 cw[cmrs_pkg::MAX_GRID];
    answer_t            due[$];
    int                 errors;

    function new();
      node_lim = 0;
      grid_lim = 0;
      errors = 0;
      foreach (gstore[i]) gstore[i] = 0;
    endfunction

    function void set_cfg(logic idx, logic [12:0] d);
      if (idx == cmrs_pkg::CFG_NODE_TOTAL)
        node_lim = (d > cmrs_pkg::MAX_NODES) ? cmrs_pkg::MAX_NODES : d;
      else grid_lim = (d[10:0] > cmrs_pkg::MAX_GRID) ? cmrs_pkg::MAX_GRID : d[10:0];
    endfunction

    // decompose reads every node and count in range, so all must be written
    function bit sweep_done();
      for (int i = 0; i < node_lim; i++) if (!nw[i]) return 0;
      for (int i = 0; i < grid_lim; i++) if (!cw[i]) return 0;
      return 1;
    endfunction

    function logic signed [31:0] to32(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
        sat = 1;
        return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        sat = 1;
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    function void note(job_t j);
      answer_t a;
      bit nok, gok, sat;
      longint m;
      nok = j.ni < node_lim;
      gok = j.gi < grid_lim;
      sat = 0;
      a.v = 0;
      a.s = cmrs_pkg::ST_OK;
      case (j.f)
        cmrs_pkg::FN_LOAD_NODE: begin
          if (nok && gok) begin
            nval[j.ni] = j.sv;
            ntgt[j.ni] = j.gi;
            nw[j.ni] = 1;
          end else a.s = cmrs_pkg::ST_RANGE;
        end
        cmrs_pkg::FN_LOAD_COUNT: begin
          if (gok) begin
            csz[j.gi] = j.cs;
            cw[j.gi] = 1;
          end else a.s = cmrs_pkg::ST_RANGE;
        end
        cmrs_pkg::FN_DECOMPOSE: begin
          // the whole grid store is cleared, not only the points in use
          foreach (gstore[i]) gstore[i] = 0;
          for (int i = 0; i < node_lim; i++)
            if (ntgt[i] < grid_lim) gstore[ntgt[i]] += longint'(nval[i]);
          for (int i = 0; i < grid_lim; i++) begin
            // SV signed divide truncates toward zero; empty cluster means 0
            m = (csz[i] == 0) ? 0 : gstore[i] / longint'({19'd0, csz[i]});
            if (m > 64'sh7FF_FFFF_FFFF) m = 64'sh7FF_FFFF_FFFF;
            if (m < -64'sh800_0000_0000) m = -64'sh800_0000_0000;
            gstore[i] = m;
          end
          for (int i = 0; i < node_lim; i++)
            if (ntgt[i] < grid_lim)
              nval[i] = to32(longint'(nval[i]) - gstore[ntgt[i]], sat);
          if (sat) a.s = cmrs_pkg::ST_SAT;
        end
        cmrs_pkg::FN_READ_MEAN: begin
          if (gok) begin
            a.v = to32(gstore[j.gi], sat);
            if (sat) a.s = cmrs_pkg::ST_SAT;
          end else a.s = cmrs_pkg::ST_RANGE;
        end
        cmrs_pkg::FN_READ_RES: begin
          if (nok) a.v = nval[j.ni];
          else a.s = cmrs_pkg::ST_RANGE;
        end
        cmrs_pkg::FN_WRITE_GRID: begin
          if (gok) gstore[j.gi] = longint'(j.sv);
          else a.s = cmrs_pkg::ST_RANGE;
        end
        cmrs_pkg::FN_RECOMPOSE: begin
          // stale target: node mapped beyond the current grid total
          if (nok && ntgt[j.ni] < grid_lim) begin
            a.v = to32(longint'(j.sv) + gstore[ntgt[j.ni]], sat);
            if (sat) a.s = cmrs_pkg::ST_SAT;
          end else a.s = cmrs_pkg::ST_RANGE;
        end
        default: ;
      endcase
      due = {due, a};
    endfunction

    function void check(logic signed [31:0] v, logic [1:0] s);
      answer_t a;
      if (due.size() == 0) begin
        $error("result with nothing outstanding: value %0d status %0d", v, s);
        errors++;
        return;
      end
      a = due.pop_front();
      if (v !== a.v) begin
        $error("result_value expected %0d got %0d", a.v, v);
        errors++;
      end
      if (s !== a.s) begin
        $error("status expected %0d got %0d", a.s, s);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [2:0] in_func;
  logic [11:0] in_node_index;
  logic [9:0] in_grid_index;
  logic signed [31:0] in_sample_value;
  logic [12:0] in_cluster_size;
  logic out_strobe;
  logic signed [31:0] out_result_value;
  logic [1:0] out_status;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [12:0] cfg_data;

  mean_split_board board;
  int sent;
  int stall;

  cluster_mean_residual_split uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_node_index(in_node_index), .in_grid_index(in_grid_index),
    .in_sample_value(in_sample_value), .in_cluster_size(in_cluster_size),
    .out_strobe(out_strobe), .out_result_value(out_result_value),
    .out_status(out_status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // results land one per strobe; the receiver has no way to stall them
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check(out_result_value, out_status);
  end

  // watchdog: any accepted item or result resets the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall <= 0;
    end else if (stall >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  // sender gap rate: light, then heavy, then none
  function int gap_pct();
    if (sent < 480) return 18;
    if (sent < 960) return 85;
    return 0;
  endfunction

  function logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3, 4, 5, 6: return $signed($urandom_range(2097151)) - 32'sd1048576;
      default: return $urandom;
    endcase
  endfunction

  // hold start high until the item is taken, then maybe leave a gap
  task send(logic [2:0] f, logic [11:0] ni, logic [9:0] gi,
            logic signed [31:0] sv, logic [12:0] cs);
    job_t j;
    j = '{f, ni, gi, sv, cs};
    start <= 1;
    in_func <= f;
    in_node_index <= ni;
    in_grid_index <= gi;
    in_sample_value <= sv;
    in_cluster_size <= cs;
    do @(posedge clk); while (busy);
    board.note(j);
    sent++;
    if ($urandom_range(99) < gap_pct()) begin
      start <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // pause the sender until every answer is back, then let the pipe empty
  task settle();
    start <= 0;
    @(posedge clk);
    while (board.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task set_totals(logic [12:0] nt, logic [12:0] gt);
    settle();
    cfg_valid <= 1;
    cfg_index <= cmrs_pkg::CFG_NODE_TOTAL;
    cfg_data <= nt;
    do @(posedge clk); while (!cfg_ready);
    board.set_cfg(cmrs_pkg::CFG_NODE_TOTAL, nt);
    cfg_index <= cmrs_pkg::CFG_GRID_TOTAL;
    cfg_data <= gt;
    do @(posedge clk); while (!cfg_ready);
    board.set_cfg(cmrs_pkg::CFG_GRID_TOTAL, gt);
    cfg_valid <= 0;
  endtask

  // well-formed setup: every node and count in range gets written;
  // the heavy form piles full-scale values onto grid point 0
  task sweep(bit heavy);
    for (int i = 0; i < board.node_lim; i++)
      send(cmrs_pkg::FN_LOAD_NODE, 12'(i),
           heavy ? 10'd0 : 10'($urandom_range(board.grid_lim - 1)),
           heavy ? 32'sh7FFF_FFFF : pick_value(), 13'd0);
    for (int i = 0; i < board.grid_lim; i++)
      send(cmrs_pkg::FN_LOAD_COUNT, 12'd0, 10'(i), 32'sd0,
           heavy ? 13'd1 : 13'($urandom_range(6)));
  endtask

  task random_items(int n);
    job_t j;
    int r;
    repeat (n) begin
      r = $urandom_range(9);
      j.ni = (r < 8 && board.node_lim > 0) ? 12'($urandom_range(board.node_lim))
                                            : 12'($urandom_range(4095));
      r = $urandom_range(9);
      j.gi = (r < 8 && board.grid_lim > 0) ? 10'($urandom_range(board.grid_lim))
                                            : 10'($urandom_range(1023));
      j.sv = pick_value();
      case ($urandom_range(7))
        0: j.cs = 13'd0;
        1: j.cs = 13'd8191;
        2: j.cs = 13'd4096;
        3: j.cs = 13'($urandom_range(8191));
        default: j.cs = 13'($urandom_range(1, 8));
      endcase
      r = $urandom_range(99);
      if (r < 20) j.f = cmrs_pkg::FN_LOAD_NODE;
      else if (r < 30) j.f = cmrs_pkg::FN_LOAD_COUNT;
      else if (r < 33) j.f = cmrs_pkg::FN_DECOMPOSE;
      else if (r < 46) j.f = cmrs_pkg::FN_READ_MEAN;
      else if (r < 60) j.f = cmrs_pkg::FN_READ_RES;
      else if (r < 68) j.f = cmrs_pkg::FN_WRITE_GRID;
      else if (r < 98) j.f = cmrs_pkg::FN_RECOMPOSE;
      else j.f = FN_UNUSED;
      // never touch a node or count that was never written
      if ((j.f == cmrs_pkg::FN_READ_RES || j.f == cmrs_pkg::FN_RECOMPOSE) &&
          j.ni < board.node_lim && !board.nw[j.ni])
        j.f = cmrs_pkg::FN_LOAD_NODE;
      if (j.f == cmrs_pkg::FN_DECOMPOSE && !board.sweep_done())
        j.f = cmrs_pkg::FN_READ_MEAN;
      send(j.f, j.ni, j.gi, j.sv, j.cs);
    end
  endtask

  task phase(logic [12:0] nt, logic [12:0] gt, bit do_sweep, int n);
    set_totals(nt, gt);
    if (do_sweep && board.grid_lim > 0) sweep(0);
    random_items(n);
  endtask

  initial begin
    board = new();
    sent = 0;
    rst_n = 0;
    start = 0;
    cfg_valid = 0;
    cfg_index = cmrs_pkg::CFG_NODE_TOTAL;
    cfg_data = 0;
    in_func = cmrs_pkg::FN_LOAD_NODE;
    in_node_index = 0;
    in_grid_index = 0;
    in_sample_value = 0;
    in_cluster_size = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: 8 nodes over 4 grid points
    set_totals(13'd8, 13'd4);
    sweep(0);
    send(cmrs_pkg::FN_LOAD_NODE, 7, 3, 32'sh7FFF_FFFF, 0);
    send(cmrs_pkg::FN_LOAD_NODE, 6, 3, 32'sh7FFF_FFFF, 0);
    send(cmrs_pkg::FN_LOAD_NODE, 5, 2, 32'sh8000_0000, 0);
    send(cmrs_pkg::FN_LOAD_NODE, 1, 0, 32'sd5, 0);
    send(cmrs_pkg::FN_LOAD_COUNT, 0, 3, 0, 13'd1);   // mean of two maxima overflows 32 bits
    send(cmrs_pkg::FN_LOAD_COUNT, 0, 2, 0, 13'd0);   // empty cluster
    send(cmrs_pkg::FN_LOAD_COUNT, 0, 1, 0, 13'd8191);
    send(cmrs_pkg::FN_LOAD_NODE, 12'd4095, 0, 32'sd1, 0);   // node out of range
    send(cmrs_pkg::FN_LOAD_NODE, 0, 10'd1023, 32'sd1, 0);   // grid out of range
    send(cmrs_pkg::FN_LOAD_COUNT, 0, 4, 0, 13'd4096);
    send(cmrs_pkg::FN_DECOMPOSE, 0, 0, 0, 0);
    for (int g = 0; g < 4; g++) send(cmrs_pkg::FN_READ_MEAN, 0, 10'(g), 0, 0);
    send(cmrs_pkg::FN_READ_RES, 7, 0, 0, 0);
    send(cmrs_pkg::FN_READ_RES, 0, 0, 0, 0);
    send(cmrs_pkg::FN_WRITE_GRID, 0, 0, 32'sh7FFF_FFFF, 0);
    send(cmrs_pkg::FN_RECOMPOSE, 1, 0, 32'sh7FFF_FFFF, 0);  // saturates high
    send(cmrs_pkg::FN_WRITE_GRID, 0, 0, 32'sh8000_0000, 0);
    send(cmrs_pkg::FN_RECOMPOSE, 1, 0, 32'sh8000_0000, 0);  // saturates low
    send(cmrs_pkg::FN_READ_RES, 12'd4095, 0, 0, 0);
    send(cmrs_pkg::FN_READ_MEAN, 0, 10'd1023, 0, 0);
    send(FN_UNUSED, 12'hFFF, 10'h3FF, 32'shFFFF_FFFF, 13'h1FFF);

    random_items(100);
    settle();                                  // mid-phase drain
    random_items(80);
    phase(13'd0, 13'd0, 0, 60);                // nothing in range
    phase(13'd16, 13'd4, 1, 200);
    phase(13'd40, 13'd9, 1, 200);
    phase(13'd40, 13'd3, 0, 100);              // shrunk grid: stale targets
    phase(13'd8191, 13'd2047, 0, 100);         // totals above the caps
    phase(13'd1, 13'd1, 1, 80);

    // every node at full scale on grid point 0
    set_totals(13'd64, 13'd16);
    sweep(1);
    send(cmrs_pkg::FN_DECOMPOSE, 0, 0, 0, 0);
    send(cmrs_pkg::FN_READ_MEAN, 0, 0, 0, 0);
    send(cmrs_pkg::FN_READ_MEAN, 0, 10'd1023, 0, 0);
    send(cmrs_pkg::FN_READ_RES, 12'd63, 0, 0, 0);
    send(cmrs_pkg::FN_RECOMPOSE, 12'd63, 0, 32'sh8000_0000, 0);
    random_items(100);

    phase(13'd64, 13'd16, 1, 150);

    settle();
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cmrs_pkg.sv
rtl/core/cmrs_div.sv
rtl/core/cluster_mean_residual_split.sv
test/cluster_mean_residual_split_tb.sv
